>>> hw/rtl/vkms_pkg.sv
package vkms_pkg;

  // Default geometry
  localparam int unsigned NumColumnsDef = 8;
  localparam int unsigned NumRowsDef    = 8;
  localparam int unsigned NumKeysDef    = 61;
  localparam int unsigned MapDepthDef   = 128;

  // Field widths
  localparam int unsigned KindW  = 2;
  localparam int unsigned ColW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NoteW  = 7;
  localparam int unsigned VelW   = 7;
  localparam int unsigned AddrW  = 7;

  // Input kinds
  localparam logic [KindW-1:0] KIND_START = 2'd0;
  localparam logic [KindW-1:0] KIND_END   = 2'd1;
  localparam logic [KindW-1:0] KIND_MAP   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 7;
  localparam logic [CfgIdxW-1:0] REG_MAX_VEL_TIME = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_NOTE    = 1'd1;

  localparam logic [CfgW-1:0] MAX_VEL_TIME_RST = 7'd70;
  localparam logic [CfgW-1:0] BASE_NOTE_RST    = 7'd36;

  localparam logic [ByteW-1:0] ALL_SENT = 8'hFF;
  localparam logic [VelW-1:0]  VEL_MIN  = 7'd1;

  // Requests to the press-time and velocity-map stores
  typedef struct packed {
    logic             pt_we;
    logic             pt_re;
    logic [AddrW-1:0] pt_addr;
    logic [ByteW-1:0] pt_wdata;
    logic             vm_we;
    logic             vm_re;
    logic [AddrW-1:0] vm_addr;
    logic [VelW-1:0]  vm_wdata;
  } vkms_mem_req_t;

  typedef struct packed {
    logic             pt_valid;
    logic [ByteW-1:0] pt_rdata;
    logic [VelW-1:0]  vm_rdata;
  } vkms_mem_rsp_t;

  // Byte push / end-of-item flush toward the output stage
  typedef struct packed {
    logic             push;
    logic             flush;
    logic [ByteW-1:0] data;
  } vkms_push_t;

endpackage

>>> hw/rtl/vkms_in_if.sv
interface vkms_in_if
  import vkms_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ColW-1:0]  column;
  logic [ByteW-1:0] switch_bits;
  logic [ByteW-1:0] timestamp;
  logic [AddrW-1:0] map_index;
  logic [VelW-1:0]  map_value;

  modport source (
    output valid, kind, column, switch_bits, timestamp, map_index, map_value,
    input  ready
  );
  modport sink (
    input  valid, kind, column, switch_bits, timestamp, map_index, map_value,
    output ready
  );
endinterface

>>> hw/rtl/vkms_out_if.sv
interface vkms_out_if
  import vkms_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last;

  modport source (
    output valid, out_byte, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last,
    output ready
  );
endinterface

>>> hw/rtl/vkms_store.sv
module vkms_store
  import vkms_pkg::*;
#(
  parameter int unsigned NUM_KEYS  = NumKeysDef,
  parameter int unsigned MAP_DEPTH = MapDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vkms_mem_req_t req_i,
  output vkms_mem_rsp_t rsp_o
);

  localparam int unsigned KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned MapW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  logic [ByteW-1:0] pt_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] pt_valid_q;
  logic [ByteW-1:0] pt_rdata_q;
  logic pt_rvalid_q;

  logic [VelW-1:0] vm_mem [MAP_DEPTH];
  logic [VelW-1:0] vm_rdata_q;

  logic [KeyW-1:0] pt_idx;
  logic [MapW-1:0] vm_idx;

  assign pt_idx = req_i.pt_addr[KeyW-1:0];
  assign vm_idx = req_i.vm_addr[MapW-1:0];

  // press time: unwritten entries read back with pt_valid low, which the sequencer takes as zero
  always_ff @(posedge clk_i) begin
    if (req_i.pt_we) begin
      pt_mem[pt_idx] <= req_i.pt_wdata;
    end
    if (req_i.pt_re) begin
      pt_rdata_q <= pt_mem[pt_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q  <= '0;
      pt_rvalid_q <= 1'b0;
    end else begin
      if (req_i.pt_we) begin
        pt_valid_q[pt_idx] <= 1'b1;
      end
      if (req_i.pt_re) begin
        pt_rvalid_q <= pt_valid_q[pt_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vm_we) begin
      vm_mem[vm_idx] <= req_i.vm_wdata;
    end
    if (req_i.vm_re) begin
      vm_rdata_q <= vm_mem[vm_idx];
    end
  end

  assign rsp_o.pt_valid = pt_rvalid_q;
  assign rsp_o.pt_rdata = pt_rdata_q;
  assign rsp_o.vm_rdata = vm_rdata_q;

endmodule

>>> hw/rtl/vkms_emit.sv
module vkms_emit
  import vkms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vkms_push_t push_i,
  output logic       room_o,
  vkms_out_if.source out_o
);

  // One byte is held back so the final one can be tagged last.
  logic             pend_v_q;
  logic [ByteW-1:0] pend_q;
  logic             out_v_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;
  logic             out_free;
  logic             move;

  assign out_free = !out_v_q || out_o.ready;
  assign room_o   = !pend_v_q || out_free;
  assign move     = pend_v_q && out_free && (push_i.push || push_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (push_i.push && room_o) begin
        pend_v_q <= 1'b1;
      end else if (push_i.flush && room_o) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_byte_q <= pend_q;
      out_last_q <= push_i.flush;
    end
    if (push_i.push && room_o) begin
      pend_q <= push_i.data;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

endmodule

>>> hw/rtl/vkms_ctrl.sv
module vkms_ctrl
  import vkms_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = NumColumnsDef,
  parameter int unsigned NUM_ROWS    = NumRowsDef,
  parameter int unsigned NUM_KEYS    = NumKeysDef,
  parameter int unsigned MAP_DEPTH   = MapDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  vkms_in_if.sink         in_i,
  input  logic [CfgW-1:0] max_vel_time_i,
  input  logic [CfgW-1:0] base_note_i,
  output vkms_mem_req_t   mem_req_o,
  input  vkms_mem_rsp_t   mem_rsp_i,
  output vkms_push_t      push_o,
  input  logic            room_i
);

  localparam int unsigned ColIdxW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned ColXW   = (ColIdxW > ColW) ? ColIdxW : ColW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ROW      = 3'd1;
  localparam logic [2:0] S_PTRD     = 3'd2;
  localparam logic [2:0] S_EMIT_ON  = 3'd3;
  localparam logic [2:0] S_EMIT_VEL = 3'd4;
  localparam logic [2:0] S_EMIT_OFF = 3'd5;
  localparam logic [2:0] S_FLUSH    = 3'd6;

  logic [2:0] state_q, state_d;

  logic [ByteW-1:0] start_seen_q [NUM_COLUMNS];
  logic [ByteW-1:0] end_seen_q   [NUM_COLUMNS];
  logic [ByteW-1:0] on_sent_q    [NUM_COLUMNS];

  logic               is_end_q;
  logic [ColIdxW-1:0] col_q;
  logic [ByteW-1:0]   bits_q, ts_q, chg_q;
  logic [ByteW-1:0]   os_q, os_d;
  logic [3:0]         row_q;
  logic [ByteW-1:0]   key_q;
  logic               use_map_q, use_map_d;

  logic               accept, col_ok, start_go, end_go, row_adv, row_done;
  logic [ColXW-1:0]   col_x;
  logic [ColIdxW-1:0] cidx;
  logic [2:0]         rb;
  logic [ByteW-1:0]   pt, t;
  logic               close, tmo;
  logic [NoteW-1:0]   note;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign col_x  = ColXW'(in_i.column);
  assign cidx   = col_x[ColIdxW-1:0];
  assign col_ok = (5'(in_i.column) < 5'(NUM_COLUMNS));

  assign rb       = row_q[2:0];
  assign row_done = (row_q == 4'(NUM_ROWS)) || (key_q >= 8'(NUM_KEYS));
  assign pt       = mem_rsp_i.pt_valid ? mem_rsp_i.pt_rdata : '0;
  assign t        = ts_q - pt;
  assign close    = chg_q[rb] && bits_q[rb];
  assign tmo      = (t >= {1'b0, max_vel_time_i});
  assign note     = base_note_i + key_q[NoteW-1:0];

  always_comb begin
    state_d   = state_q;
    os_d      = os_q;
    use_map_d = use_map_q;
    row_adv   = 1'b0;
    start_go  = 1'b0;
    end_go    = 1'b0;
    mem_req_o = '0;
    push_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.kind == KIND_MAP) begin
            mem_req_o.vm_we    = (8'(in_i.map_index) < 8'(MAP_DEPTH));
            mem_req_o.vm_addr  = in_i.map_index;
            mem_req_o.vm_wdata = in_i.map_value;
          end else if (in_i.kind == KIND_START && col_ok) begin
            start_go = 1'b1;
            state_d  = S_ROW;
          end else if (in_i.kind == KIND_END && col_ok && on_sent_q[cidx] != ALL_SENT) begin
            end_go  = 1'b1;
            state_d = S_ROW;
          end
        end
      end
      S_ROW: begin
        mem_req_o.pt_addr  = key_q[AddrW-1:0];
        mem_req_o.pt_wdata = ts_q;
        if (row_done) begin
          state_d = S_FLUSH;
        end else if (!is_end_q) begin
          if (chg_q[rb]) begin
            if (bits_q[rb]) begin
              mem_req_o.pt_we = 1'b1;
              os_d[rb] = 1'b0;
              row_adv  = 1'b1;
            end else if (os_q[rb]) begin
              state_d = S_EMIT_OFF;
            end else begin
              os_d[rb] = 1'b1;
              row_adv  = 1'b1;
            end
          end else begin
            row_adv = 1'b1;
          end
        end else if (os_q[rb]) begin
          row_adv = 1'b1;
        end else begin
          mem_req_o.pt_re = 1'b1;
          state_d = S_PTRD;
        end
      end
      S_PTRD: begin
        mem_req_o.vm_addr = t[AddrW-1:0];
        if (close || tmo) begin
          use_map_d = close && !tmo && (t < 8'(MAP_DEPTH));
          mem_req_o.vm_re = use_map_d;
          os_d[rb] = 1'b1;
          state_d  = S_EMIT_ON;
        end else begin
          row_adv = 1'b1;
          state_d = S_ROW;
        end
      end
      S_EMIT_ON: begin
        push_o.push = 1'b1;
        push_o.data = {1'b1, note};
        if (room_i) begin
          state_d = S_EMIT_VEL;
        end
      end
      S_EMIT_VEL: begin
        push_o.push = 1'b1;
        push_o.data = {1'b0, (use_map_q ? mem_rsp_i.vm_rdata : VEL_MIN)};
        if (room_i) begin
          row_adv = 1'b1;
          state_d = S_ROW;
        end
      end
      S_EMIT_OFF: begin
        push_o.push = 1'b1;
        push_o.data = {1'b0, note};
        if (room_i) begin
          row_adv = 1'b1;
          state_d = S_ROW;
        end
      end
      S_FLUSH: begin
        push_o.flush = 1'b1;
        if (room_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      use_map_q <= 1'b0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        start_seen_q[i] <= '0;
        end_seen_q[i]   <= '0;
        on_sent_q[i]    <= ALL_SENT;
      end
    end else begin
      state_q   <= state_d;
      use_map_q <= use_map_d;
      if (start_go) begin
        start_seen_q[cidx] <= in_i.switch_bits;
      end
      if (end_go) begin
        end_seen_q[cidx] <= in_i.switch_bits;
      end
      if (state_q == S_FLUSH && room_i) begin
        on_sent_q[col_q] <= os_q;
      end
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_end_q <= (in_i.kind == KIND_END);
      col_q    <= cidx;
      bits_q   <= in_i.switch_bits;
      ts_q     <= in_i.timestamp;
      chg_q    <= in_i.switch_bits ^
                  ((in_i.kind == KIND_END) ? end_seen_q[cidx] : start_seen_q[cidx]);
      os_q     <= on_sent_q[cidx];
      row_q    <= '0;
      key_q    <= ByteW'(in_i.column);
    end else begin
      os_q <= os_d;
      if (row_adv) begin
        row_q <= row_q + 4'd1;
        key_q <= key_q + 8'(NUM_COLUMNS);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW |-> row_q <= 4'(NUM_ROWS))
    else $error("row counter past last row");

  a_ptrd_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PTRD |-> $past(state_q) == S_ROW)
    else $error("press-time data used without a read");

  a_pt_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.pt_we && mem_req_o.pt_re))
    else $error("press-time store read and written together");

  a_vel_after_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT_VEL |->
      ($past(state_q) == S_EMIT_ON || $past(state_q) == S_EMIT_VEL))
    else $error("velocity byte without note-on");
`endif

endmodule

>>> hw/rtl/velocity_key_matrix_scanner_top.sv
// Channel  Dir  Payload                                                     Handshake
// in_i     in   kind, column, switch_bits, timestamp, map_index, map_value  valid/ready
// out_o    out  out_byte, last                                              valid/ready
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i                            write strobe only
//
// Sequencing: a map write or ignored request is handled in the idle state. A start- or
//   end-switch request walks its rows with the one row-per-step sequencer, pushing bytes
//   as it goes; for each pending key an end-switch request first reads the single
//   press-time store port, then decides.
// Reset: async, active low; clears contact history, marks all notes as sent, and
//   invalidates all press times (they read as zero). The velocity map is not cleared.
// Stalls: one byte is held back to tag the last one; the next byte waits while the output
//   register is full and out_o.ready is low. A new request is taken as soon as the final
//   byte sits in the output register.
module velocity_key_matrix_scanner_top
  import vkms_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = NumColumnsDef,
  parameter int unsigned NUM_ROWS    = NumRowsDef,
  parameter int unsigned NUM_KEYS    = NumKeysDef,
  parameter int unsigned MAP_DEPTH   = MapDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  vkms_in_if.sink            in_i,
  vkms_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic [CfgW-1:0] max_vel_time_q;
  logic [CfgW-1:0] base_note_q;

  vkms_mem_req_t mem_req;
  vkms_mem_rsp_t mem_rsp;
  vkms_push_t    push;
  logic          room;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_time_q <= MAX_VEL_TIME_RST;
      base_note_q    <= BASE_NOTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_VEL_TIME: max_vel_time_q <= cfg_wdata_i;
        REG_BASE_NOTE:    base_note_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // row sequencer: walks one column's rows, decides note-on/off per key
  vkms_ctrl #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS),
    .NUM_KEYS    (NUM_KEYS),
    .MAP_DEPTH   (MAP_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .max_vel_time_i (max_vel_time_q),
    .base_note_i    (base_note_q),
    .mem_req_o      (mem_req),
    .mem_rsp_i      (mem_rsp),
    .push_o         (push),
    .room_i         (room)
  );

  // press-time and velocity-map memories
  vkms_store #(
    .NUM_KEYS  (NUM_KEYS),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  // byte staging and last tagging
  vkms_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

>>> dv/vkms_midi_check.sv
`timescale 1ns / 100ps

module vkms_midi_check
  import vkms_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = NumColumnsDef,
  parameter int unsigned NUM_ROWS    = NumRowsDef,
  parameter int unsigned NUM_KEYS    = NumKeysDef,
  parameter int unsigned MAP_DEPTH   = MapDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  vkms_in_if                 in_mon,
  vkms_out_if                out_mon,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        bytes_due_o
);

  localparam int unsigned PrintCap = 100;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } midi_byte_t;

  logic [CfgW-1:0]  timeout_ticks;
  logic [CfgW-1:0]  note_base;
  logic [ByteW-1:0] start_contacts [NUM_COLUMNS];
  logic [ByteW-1:0] end_contacts   [NUM_COLUMNS];
  logic [ByteW-1:0] note_on_done   [NUM_COLUMNS];
  logic [ByteW-1:0] press_stamp    [NUM_KEYS];
  logic [VelW-1:0]  vel_table      [MAP_DEPTH];
  midi_byte_t       midi_due[$];

  initial begin
    fail_count_o = 0;
    bytes_due_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PrintCap) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  function automatic logic [NoteW-1:0] note_num(input int unsigned key);
    return NoteW'(note_base + key);  // wraps mod 128
  endfunction

  function automatic logic [VelW-1:0] velocity_of(input logic [ByteW-1:0] elapsed);
    if (elapsed < timeout_ticks && elapsed < MAP_DEPTH) begin
      return vel_table[elapsed];
    end
    return VEL_MIN;
  endfunction

  task automatic queue_byte(input logic [ByteW-1:0] value);
    midi_due.push_back('{out_byte: value, last: 1'b0});
  endtask

  task automatic scan_start(input int unsigned col, input logic [ByteW-1:0] contacts,
                            input logic [ByteW-1:0] stamp);
    logic [ByteW-1:0] changed;
    int unsigned      key;
    changed = start_contacts[col] ^ contacts;
    for (int unsigned row = 0; row < NUM_ROWS && row < ByteW; row++) begin
      key = col + row * NUM_COLUMNS;
      if (key >= NUM_KEYS) break;
      if (changed[row]) begin
        if (contacts[row]) begin
          press_stamp[key]       = stamp;
          note_on_done[col][row] = 1'b0;
        end else if (note_on_done[col][row]) begin
          queue_byte({1'b0, note_num(key)});
        end else begin
          // released before the bottom contact: drop silently
          note_on_done[col][row] = 1'b1;
        end
      end
    end
    start_contacts[col] = contacts;
  endtask

  task automatic scan_end(input int unsigned col, input logic [ByteW-1:0] contacts,
                          input logic [ByteW-1:0] stamp);
    logic [ByteW-1:0] changed;
    logic [ByteW-1:0] elapsed;
    int unsigned      key;
    if (note_on_done[col] == ALL_SENT) return;
    changed = end_contacts[col] ^ contacts;
    for (int unsigned row = 0; row < NUM_ROWS && row < ByteW; row++) begin
      key = col + row * NUM_COLUMNS;
      if (key >= NUM_KEYS) break;
      if (note_on_done[col][row]) continue;
      elapsed = stamp - press_stamp[key];
      if (changed[row] && contacts[row]) begin
        queue_byte({1'b1, note_num(key)});
        queue_byte({1'b0, velocity_of(elapsed)});
        note_on_done[col][row] = 1'b1;
      end else if (elapsed >= timeout_ticks) begin
        queue_byte({1'b1, note_num(key)});
        queue_byte({1'b0, VEL_MIN});
        note_on_done[col][row] = 1'b1;
      end
    end
    end_contacts[col] = contacts;
  endtask

  task automatic predict_request();
    int unsigned due_prior;
    midi_byte_t  tail;
    due_prior = midi_due.size();
    case (in_mon.kind)
      KIND_MAP: begin
        if (in_mon.map_index < MAP_DEPTH) vel_table[in_mon.map_index] = in_mon.map_value;
      end
      KIND_START: begin
        if (in_mon.column < NUM_COLUMNS) begin
          scan_start(in_mon.column, in_mon.switch_bits, in_mon.timestamp);
        end
      end
      KIND_END: begin
        if (in_mon.column < NUM_COLUMNS) begin
          scan_end(in_mon.column, in_mon.switch_bits, in_mon.timestamp);
        end
      end
      default: ;
    endcase
    if (midi_due.size() > due_prior) begin
      tail      = midi_due.pop_back();
      tail.last = 1'b1;
      midi_due.push_back(tail);
    end
  endtask

  task automatic check_byte();
    midi_byte_t want;
    if (midi_due.size() == 0) begin
      report_mismatch($sformatf("unexpected byte 0x%02h last %0b",
                                out_mon.out_byte, out_mon.last));
    end else begin
      want = midi_due.pop_front();
      if (out_mon.out_byte !== want.out_byte) begin
        report_mismatch($sformatf("out_byte 0x%02h, predicted 0x%02h",
                                  out_mon.out_byte, want.out_byte));
      end
      if (out_mon.last !== want.last) begin
        report_mismatch($sformatf("last %0b on byte 0x%02h, predicted %0b",
                                  out_mon.last, want.out_byte, want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks = MAX_VEL_TIME_RST;
      note_base     = BASE_NOTE_RST;
      for (int unsigned c = 0; c < NUM_COLUMNS; c++) begin
        start_contacts[c] = '0;
        end_contacts[c]   = '0;
        note_on_done[c]   = ALL_SENT;
      end
      for (int unsigned k = 0; k < NUM_KEYS; k++) press_stamp[k] = '0;
      midi_due.delete();
      bytes_due_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_byte();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_VEL_TIME: timeout_ticks = cfg_wdata_i;
          REG_BASE_NOTE:    note_base     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_request();
      bytes_due_o = midi_due.size();
    end
  end

endmodule

>>> dv/velocity_key_matrix_scanner_top_tb.sv
`timescale 1ns / 100ps

module velocity_key_matrix_scanner_top_tb;
  import vkms_pkg::*;

  // kind code the block must ignore
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned NumPhases     = 5;
  localparam int unsigned ReqsPerPhase  = 66;
  // give the block ample room to finish a start/end scan after the last byte
  localparam int unsigned SettleCycles  = 48;
  // watchdog limit on a stretch without any request moving
  localparam int unsigned QuietLimit    = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  int unsigned fail_count;
  int unsigned bytes_due;
  int unsigned quiet_cycles = 0;

  // percent chance of a gap before a request / a stall on the byte side
  int unsigned in_gap_pct    = 25;
  int unsigned out_stall_pct = 25;

  // what the player's fingers are doing, per column; only shapes stimulus
  logic [ByteW-1:0] start_held [NumColumnsDef];
  logic [ByteW-1:0] end_held   [NumColumnsDef];
  logic [ByteW-1:0] tick;

  vkms_in_if  key_scan_if ();
  vkms_out_if midi_if ();

  velocity_key_matrix_scanner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (key_scan_if),
    .out_o       (midi_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predicts every byte from the accepted requests and compares in order
  vkms_midi_check midi_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (key_scan_if),
    .out_mon      (midi_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .bytes_due_o  (bytes_due)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: trips only when no request moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (key_scan_if.valid && key_scan_if.ready) ||
        (midi_if.valid && midi_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d bytes still due",
               QuietLimit, bytes_due);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Byte side: random stall bursts, after each of which ready is raised again.
  initial begin
    midi_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && $urandom_range(0, 99) < out_stall_pct) begin
        midi_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      midi_if.ready <= 1'b1;
    end
  end

  // Sends one request. Entered and left at a falling edge; valid stays high
  // on return so back-to-back requests follow without a gap.
  task automatic send_req(input logic [KindW-1:0] kind, input logic [ColW-1:0] col,
                          input logic [ByteW-1:0] contacts, input logic [ByteW-1:0] stamp,
                          input logic [AddrW-1:0] idx, input logic [VelW-1:0] vel);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      key_scan_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    key_scan_if.valid       <= 1'b1;
    key_scan_if.kind        <= kind;
    key_scan_if.column      <= col;
    key_scan_if.switch_bits <= contacts;
    key_scan_if.timestamp   <= stamp;
    key_scan_if.map_index   <= idx;
    key_scan_if.map_value   <= vel;
    do @(posedge clk_i); while (!key_scan_if.ready);
    @(negedge clk_i);
  endtask

  // Scan request with don't-care map fields randomized.
  task automatic send_scan(input logic [KindW-1:0] kind, input logic [ColW-1:0] col,
                           input logic [ByteW-1:0] contacts, input logic [ByteW-1:0] stamp);
    send_req(kind, col, contacts, stamp, AddrW'($urandom_range(0, 127)),
             VelW'($urandom_range(1, 127)));
  endtask

  // Stop sending, let every predicted byte drain, then let the block go idle
  // (a request that makes no bytes may still be in flight).
  task automatic drain();
    key_scan_if.valid <= 1'b0;
    while (bytes_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes both registers on consecutive cycles; we stays high across them.
  task automatic load_settings(input logic [CfgW-1:0] max_ticks, input logic [CfgW-1:0] note0);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MAX_VEL_TIME;
    cfg_wdata_i <= max_ticks;
    @(negedge clk_i);
    cfg_idx_i   <= REG_BASE_NOTE;
    cfg_wdata_i <= note0;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One step of play: mostly physically sensible contact sequences (start
  // closes before end, end opens before start) with random timing, plus
  // map rewrites and some fully random noise.
  task automatic play_step();
    int unsigned      col;
    int unsigned      pick;
    logic [ByteW-1:0] contacts;
    col  = $urandom_range(0, NumColumnsDef - 1);
    pick = $urandom_range(0, 99);
    // small steps give real velocities; the odd big jump forces timeouts and wraps
    if ($urandom_range(0, 19) == 0) tick += ByteW'($urandom_range(40, 220));
    else tick += ByteW'($urandom_range(0, 9));
    if (pick < 45) begin
      for (int r = 0; r < ByteW; r++) begin
        if (!start_held[col][r]) begin
          if ($urandom_range(0, 9) < 3) start_held[col][r] = 1'b1;
        end else if (!end_held[col][r] && $urandom_range(0, 9) < 2) begin
          start_held[col][r] = 1'b0;
        end
      end
      send_scan(KIND_START, ColW'(col), start_held[col], tick);
    end else if (pick < 88) begin
      for (int r = 0; r < ByteW; r++) begin
        if (end_held[col][r]) begin
          if ($urandom_range(0, 9) < 3) end_held[col][r] = 1'b0;
        end else if (start_held[col][r] && $urandom_range(0, 9) < 4) begin
          end_held[col][r] = 1'b1;
        end
      end
      send_scan(KIND_END, ColW'(col), end_held[col], tick);
    end else if (pick < 94) begin
      send_req(KIND_MAP, ColW'($urandom_range(0, 7)), ByteW'($urandom),
               ByteW'($urandom), AddrW'($urandom_range(0, 127)),
               VelW'($urandom_range(1, 127)));
    end else begin
      contacts = ByteW'($urandom);
      send_req(KindW'($urandom_range(0, 3)), ColW'($urandom_range(0, 7)), contacts,
               ByteW'($urandom), AddrW'($urandom_range(0, 127)),
               VelW'($urandom_range(1, 127)));
    end
  endtask

  initial begin
    logic [CfgW-1:0] max_ticks [NumPhases];
    logic [CfgW-1:0] note0     [NumPhases];

    // everything driven to a known value from time zero
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = REG_MAX_VEL_TIME;
    cfg_wdata_i             = '0;
    key_scan_if.valid       = 1'b0;
    key_scan_if.kind        = KIND_START;
    key_scan_if.column      = '0;
    key_scan_if.switch_bits = '0;
    key_scan_if.timestamp   = '0;
    key_scan_if.map_index   = '0;
    key_scan_if.map_value   = VEL_MIN;
    tick                    = '0;
    for (int c = 0; c < NumColumnsDef; c++) begin
      start_held[c] = '0;
      end_held[c]   = '0;
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Velocity map is undefined after reset, so fill every entry before any
    // end-switch request can look one up. Values sweep 1..127 in scrambled order.
    for (int i = 0; i < MapDepthDef; i++) begin
      send_req(KIND_MAP, ColW'($urandom_range(0, 7)), ByteW'($urandom), ByteW'($urandom),
               AddrW'(i), VelW'((i * 37 + 11) % 127 + 1));
    end

    // Directed part, at reset settings (timeout 70, base note 36).
    send_scan(KIND_START, 3'd0, 8'hFF, 8'd0);    // all eight keys of column 0 go down
    send_scan(KIND_END,   3'd0, 8'h01, 8'd5);    // key 0 strikes, velocity from the map
    send_scan(KIND_END,   3'd0, 8'h01, 8'd69);   // one tick short of the timeout: nothing
    send_scan(KIND_END,   3'd0, 8'h01, 8'd70);   // seven keys time out, velocity 1
    send_scan(KIND_END,   3'd0, 8'hFF, 8'd80);   // all presses settled: ignored
    send_scan(KIND_START, 3'd0, 8'h00, 8'd90);   // eight note-offs
    send_scan(KIND_START, 3'd4, 8'hFF, 8'd250);  // full column near the counter wrap
    send_scan(KIND_END,   3'd4, 8'hFF, 8'd3);    // elapsed time wraps; sixteen bytes
    send_scan(KIND_START, 3'd4, 8'h00, 8'd4);
    send_scan(KIND_END,   3'd4, 8'h00, 8'd5);    // nothing pending
    send_scan(KIND_START, 3'd7, 8'hFF, 8'd20);   // row 7 of column 7 is not a key
    send_scan(KIND_END,   3'd7, 8'h80, 8'd21);   // only the non-key row closes
    send_scan(KIND_END,   3'd7, 8'h7F, 8'd22);
    send_scan(KIND_START, 3'd2, 8'h01, 8'd30);
    send_scan(KIND_START, 3'd2, 8'h00, 8'd31);   // released before bottom: silent
    send_scan(KIND_END,   3'd2, 8'h01, 8'd32);   // nothing pending
    send_scan(KIND_UNUSED, 3'd3, 8'hFF, 8'hFF);  // unused kind: ignored
    send_scan(KIND_START, 3'd7, 8'h00, 8'd40);   // note-offs for seven real keys
    send_scan(KIND_END,   3'd0, 8'h00, 8'd41);
    send_scan(KIND_END,   3'd7, 8'h00, 8'd42);

    // Random phases: defaults written back explicitly, then both extremes,
    // then random settings. The last phase runs with no idling at all.
    max_ticks[0] = MAX_VEL_TIME_RST;  note0[0] = BASE_NOTE_RST;
    max_ticks[1] = 7'd1;              note0[1] = 7'd0;
    max_ticks[2] = 7'd127;            note0[2] = 7'd67;
    for (int p = 3; p < NumPhases; p++) begin
      max_ticks[p] = CfgW'($urandom_range(1, 127));
      note0[p]     = CfgW'($urandom_range(0, 67));
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      load_settings(max_ticks[p], note0[p]);
      in_gap_pct    = (p == NumPhases - 1) ? 0 : 10 + 10 * p;
      out_stall_pct = (p == NumPhases - 1) ? 0 : 40 - 8 * p;
      for (int n = 0; n < ReqsPerPhase; n++) begin
        // hold the sender once until every byte is out, mid-stream
        if (p == 2 && n == ReqsPerPhase / 2) drain();
        play_step();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
